### src/scp_pkg.sv
// Shared widths, constants and types for the segment closest points pipeline.
package scp_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int RATIO_FRACTION_BITS = 16;
    localparam int LIMIT_WIDTH = 8;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int DOT_W = 2 * DIFF_W + 1;
    localparam int PROD_W = 2 * DOT_W;
    localparam int QUAD_W = PROD_W + 1;
    localparam int RATIO_W = RATIO_FRACTION_BITS + 1;
    localparam int GAP_W = COORD_WIDTH + 1;
    localparam int SUM_W = 2 * DIFF_W;

    localparam logic [RATIO_W-1:0] RATIO_ONE = {1'b1, {RATIO_FRACTION_BITS{1'b0}}};

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_start_x;
        logic signed [COORD_WIDTH-1:0] first_start_y;
        logic signed [COORD_WIDTH-1:0] first_end_x;
        logic signed [COORD_WIDTH-1:0] first_end_y;
        logic signed [COORD_WIDTH-1:0] second_start_x;
        logic signed [COORD_WIDTH-1:0] second_start_y;
        logic signed [COORD_WIDTH-1:0] second_end_x;
        logic signed [COORD_WIDTH-1:0] second_end_y;
    } scp_request_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] near_first_x;
        logic signed [COORD_WIDTH-1:0] near_first_y;
        logic signed [COORD_WIDTH-1:0] near_second_x;
        logic signed [COORD_WIDTH-1:0] near_second_y;
        logic [GAP_W-1:0]              gap_length;
    } scp_result_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] p1x;
        logic signed [COORD_WIDTH-1:0] p1y;
        logic signed [COORD_WIDTH-1:0] p2x;
        logic signed [COORD_WIDTH-1:0] p2y;
        logic signed [DIFF_W-1:0]      d1x;
        logic signed [DIFF_W-1:0]      d1y;
        logic signed [DIFF_W-1:0]      d2x;
        logic signed [DIFF_W-1:0]      d2y;
        logic signed [DOT_W-1:0]       a;
        logic signed [DOT_W-1:0]       e;
        logic signed [DOT_W-1:0]       b;
        logic signed [DOT_W-1:0]       c;
        logic signed [DOT_W-1:0]       f;
    } scp_geo_t;

    typedef struct packed {
        scp_geo_t                 geo;
        logic                     a_pt;
        logic                     e_pt;
        logic signed [QUAD_W-1:0] denom;
        logic signed [QUAD_W-1:0] snum;
    } scp_front_t;

endpackage

### src/scp_div.sv
// Pipelined restoring divider giving a ratio clamped to 0..1, one quotient bit per stage.
module scp_div #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 8,
    parameter int SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic signed [NUM_W-1:0]       num,
    input  logic signed [DEN_W-1:0]       den,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_vld,
    output logic [scp_pkg::RATIO_W-1:0]   quo,
    output logic [SIDE_W-1:0]             side_out
);
    import scp_pkg::*;

    localparam int CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;
    localparam int RF = RATIO_FRACTION_BITS;

    logic signed [CMP_W-1:0] num_ext;
    logic signed [CMP_W-1:0] den_ext;
    logic                    vld_reg  [0:RF];
    logic                    zero_reg [0:RF];
    logic                    one_reg  [0:RF];
    logic [DEN_W-1:0]        rem_reg  [0:RF];
    logic [DEN_W-1:0]        den_reg  [0:RF];
    logic [RF-1:0]           quo_reg  [0:RF];
    logic [SIDE_W-1:0]       side_reg [0:RF];
    logic [DEN_W-1:0]        shl      [1:RF];
    logic                    geq      [1:RF];

    assign num_ext = CMP_W'(num);
    assign den_ext = CMP_W'(den);

    always_comb
    begin
        for (int k = 1; k <= RF; k++)
        begin
            shl[k] = {rem_reg[k-1][DEN_W-2:0], 1'b0};
            geq[k] = shl[k] >= den_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= RF; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k <= RF; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (den_ext <= 0) || (num_ext <= 0);
            one_reg[0]  <= num_ext >= den_ext;
            rem_reg[0]  <= DEN_W'(num);
            den_reg[0]  <= $unsigned(den);
            quo_reg[0]  <= '0;
            side_reg[0] <= side_in;
            for (int k = 1; k <= RF; k++)
            begin
                zero_reg[k] <= zero_reg[k-1];
                one_reg[k]  <= one_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
                if (geq[k])
                begin
                    rem_reg[k] <= shl[k] - den_reg[k-1];
                    quo_reg[k] <= {quo_reg[k-1][RF-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= shl[k];
                    quo_reg[k] <= {quo_reg[k-1][RF-2:0], 1'b0};
                end
            end
        end
    end

    assign out_vld  = vld_reg[RF];
    assign side_out = side_reg[RF];
    assign quo = zero_reg[RF] ? '0 : (one_reg[RF] ? RATIO_ONE : {1'b0, quo_reg[RF]});

endmodule

### src/scp_sqrt.sv
// Pipelined bit-by-bit integer square root, one result bit per stage.
module scp_sqrt #(
    parameter int SUM_W = 34,
    parameter int ROOT_W = 17,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [SUM_W-1:0]  sum,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [ROOT_W-1:0] root,
    output logic [SIDE_W-1:0] side_out
);
    localparam int SQ_W = 2 * ROOT_W + 1;
    localparam int CMP_W = (SQ_W > SUM_W) ? SQ_W : SUM_W;

    logic              vld_reg  [0:ROOT_W];
    logic [SUM_W-1:0]  sum_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    logic [SQ_W-1:0]   sq_reg   [0:ROOT_W];
    logic [SIDE_W-1:0] side_reg [0:ROOT_W];
    logic [SQ_W-1:0]   cand_sq  [1:ROOT_W];
    logic              fits     [1:ROOT_W];

    always_comb
    begin
        for (int k = 1; k <= ROOT_W; k++)
        begin
            cand_sq[k] = sq_reg[k-1] + (SQ_W'(root_reg[k-1]) << (ROOT_W - k + 1))
                + (SQ_W'(1) << (2 * (ROOT_W - k)));
            fits[k] = CMP_W'(sum_reg[k-1]) >= CMP_W'(cand_sq[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ROOT_W; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k <= ROOT_W; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg[0]  <= sum;
            root_reg[0] <= '0;
            sq_reg[0]   <= '0;
            side_reg[0] <= side_in;
            for (int k = 1; k <= ROOT_W; k++)
            begin
                sum_reg[k]  <= sum_reg[k-1];
                side_reg[k] <= side_reg[k-1];
                if (fits[k])
                begin
                    root_reg[k] <= root_reg[k-1] | (ROOT_W'(1) << (ROOT_W - k));
                    sq_reg[k]   <= cand_sq[k];
                end
                else
                begin
                    root_reg[k] <= root_reg[k-1];
                    sq_reg[k]   <= sq_reg[k-1];
                end
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W];
    assign root     = root_reg[ROOT_W];
    assign side_out = side_reg[ROOT_W];

endmodule

### src/scp_front.sv
// Front stages: segment differences, dot products, point tests and the determinant.
module scp_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_vld,
    input  scp_pkg::scp_request_t             request,
    input  logic [scp_pkg::LIMIT_WIDTH-1:0]   limit,
    output logic                              out_vld,
    output scp_pkg::scp_front_t               front
);
    import scp_pkg::*;

    function automatic logic signed [DOT_W-1:0] dot(
        input logic signed [DIFF_W-1:0] ax,
        input logic signed [DIFF_W-1:0] ay,
        input logic signed [DIFF_W-1:0] bx,
        input logic signed [DIFF_W-1:0] by
    );
        return DOT_W'(ax) * DOT_W'(bx) + DOT_W'(ay) * DOT_W'(by);
    endfunction

    logic vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg;
    logic signed [COORD_WIDTH-1:0] p1x_a_reg, p1y_a_reg, p2x_a_reg, p2y_a_reg;
    logic signed [DIFF_W-1:0] d1x_a_reg, d1y_a_reg, d2x_a_reg, d2y_a_reg;
    logic signed [DIFF_W-1:0] rx_a_reg, ry_a_reg;
    scp_geo_t geo_b_next, geo_b_reg, geo_c_reg;
    logic a_pt_c_reg, e_pt_c_reg;
    logic signed [PROD_W-1:0] ae_c_reg, bb_c_reg, bf_c_reg, ce_c_reg;
    logic signed [DOT_W-1:0] lim_ext;
    scp_front_t front_reg;

    assign lim_ext = $signed({{(DOT_W - LIMIT_WIDTH){1'b0}}, limit});

    always_comb
    begin
        geo_b_next.p1x = p1x_a_reg;
        geo_b_next.p1y = p1y_a_reg;
        geo_b_next.p2x = p2x_a_reg;
        geo_b_next.p2y = p2y_a_reg;
        geo_b_next.d1x = d1x_a_reg;
        geo_b_next.d1y = d1y_a_reg;
        geo_b_next.d2x = d2x_a_reg;
        geo_b_next.d2y = d2y_a_reg;
        geo_b_next.a = dot(d1x_a_reg, d1y_a_reg, d1x_a_reg, d1y_a_reg);
        geo_b_next.e = dot(d2x_a_reg, d2y_a_reg, d2x_a_reg, d2y_a_reg);
        geo_b_next.b = dot(d1x_a_reg, d1y_a_reg, d2x_a_reg, d2y_a_reg);
        geo_b_next.c = dot(d1x_a_reg, d1y_a_reg, rx_a_reg, ry_a_reg);
        geo_b_next.f = dot(d2x_a_reg, d2y_a_reg, rx_a_reg, ry_a_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1x_a_reg <= request.first_start_x;
            p1y_a_reg <= request.first_start_y;
            p2x_a_reg <= request.second_start_x;
            p2y_a_reg <= request.second_start_y;
            d1x_a_reg <= DIFF_W'($signed(request.first_end_x))
                - DIFF_W'($signed(request.first_start_x));
            d1y_a_reg <= DIFF_W'($signed(request.first_end_y))
                - DIFF_W'($signed(request.first_start_y));
            d2x_a_reg <= DIFF_W'($signed(request.second_end_x))
                - DIFF_W'($signed(request.second_start_x));
            d2y_a_reg <= DIFF_W'($signed(request.second_end_y))
                - DIFF_W'($signed(request.second_start_y));
            rx_a_reg <= DIFF_W'($signed(request.first_start_x))
                - DIFF_W'($signed(request.second_start_x));
            ry_a_reg <= DIFF_W'($signed(request.first_start_y))
                - DIFF_W'($signed(request.second_start_y));

            geo_b_reg <= geo_b_next;

            geo_c_reg  <= geo_b_reg;
            a_pt_c_reg <= $signed(geo_b_reg.a) <= lim_ext;
            e_pt_c_reg <= $signed(geo_b_reg.e) <= lim_ext;
            ae_c_reg <= PROD_W'($signed(geo_b_reg.a)) * PROD_W'($signed(geo_b_reg.e));
            bb_c_reg <= PROD_W'($signed(geo_b_reg.b)) * PROD_W'($signed(geo_b_reg.b));
            bf_c_reg <= PROD_W'($signed(geo_b_reg.b)) * PROD_W'($signed(geo_b_reg.f));
            ce_c_reg <= PROD_W'($signed(geo_b_reg.c)) * PROD_W'($signed(geo_b_reg.e));

            front_reg.geo   <= geo_c_reg;
            front_reg.a_pt  <= a_pt_c_reg;
            front_reg.e_pt  <= e_pt_c_reg;
            front_reg.denom <= QUAD_W'(ae_c_reg) - QUAD_W'(bb_c_reg);
            front_reg.snum  <= QUAD_W'(bf_c_reg) - QUAD_W'(ce_c_reg);
        end
    end

    assign out_vld = vld_d_reg;
    assign front   = front_reg;

endmodule

### src/segment_closest_points_2d.sv
// Depth: 62 register stages lie between an accepted request and its valid result.
// Throughput: one request per cycle; the whole pipeline advances unless a result is held.
// Depth is set by two 17-stage ratio dividers and an 18-stage square root, one bit per stage.
// Stalls freeze every stage at once, so no request is lost or repeated.
// Reset clears all valid bits and sets degenerate_limit to zero.
module segment_closest_points_2d (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              request_valid,
    output logic                              request_ready,
    input  scp_pkg::scp_request_t             request,
    output logic                              result_valid,
    input  logic                              result_ready,
    output scp_pkg::scp_result_t              result,
    input  logic                              cfg_write_en,
    input  logic [scp_pkg::LIMIT_WIDTH-1:0]   cfg_write_data
);
    import scp_pkg::*;

    localparam int BS_W = DOT_W + RATIO_W + 1;
    localparam int TN_W = BS_W + 1;
    localparam int M_W = DIFF_W + RATIO_W + 1;
    localparam logic signed [M_W:0] HALF = (M_W + 1)'(1) <<< (RATIO_FRACTION_BITS - 1);

    typedef struct packed {
        scp_geo_t geo;
        logic     a_pt;
        logic     e_pt;
    } side1_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] p1x;
        logic signed [COORD_WIDTH-1:0] p1y;
        logic signed [COORD_WIDTH-1:0] p2x;
        logic signed [COORD_WIDTH-1:0] p2y;
        logic signed [DIFF_W-1:0]      d1x;
        logic signed [DIFF_W-1:0]      d1y;
        logic signed [DIFF_W-1:0]      d2x;
        logic signed [DIFF_W-1:0]      d2y;
        logic [RATIO_W-1:0]            s;
        logic [RATIO_W-1:0]            t;
        logic                          tgt_s;
        logic                          tgt_t;
    } side2_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] c1x;
        logic signed [COORD_WIDTH-1:0] c1y;
        logic signed [COORD_WIDTH-1:0] c2x;
        logic signed [COORD_WIDTH-1:0] c2y;
    } pts_t;

    function automatic logic signed [COORD_WIDTH-1:0] step_along(
        input logic signed [COORD_WIDTH-1:0] p,
        input logic signed [M_W-1:0]         m
    );
        logic signed [M_W:0] v;
        v = (M_W + 1)'(m) + HALF;
        return p + COORD_WIDTH'(v >>> RATIO_FRACTION_BITS);
    endfunction

    logic en;
    logic [LIMIT_WIDTH-1:0] degenerate_limit_reg;

    logic       front_vld;
    scp_front_t front;

    logic signed [QUAD_W-1:0] num1, den1;
    side1_t side1_in, side1_out;
    logic [$bits(side1_t)-1:0] side1_bits;
    logic div1_vld;
    logic [RATIO_W-1:0] q1;

    logic [RATIO_W-1:0] s1, t1;
    logic               vld_t1_reg, vld_t2_reg, vld_t3_reg;
    scp_geo_t           geo_t1_reg, geo_t2_reg;
    logic               general_t1_reg, general_t2_reg;
    logic [RATIO_W-1:0] s_t1_reg, t_t1_reg, s_t2_reg, t_t2_reg;
    logic signed [BS_W-1:0] bs_t1_reg;
    logic signed [TN_W-1:0] tn_t2_reg, tden_t2_reg;

    logic signed [TN_W-1:0] num2_next, den2_next, num2_reg, den2_reg;
    side2_t side2_next, side2_reg, side2_out;
    logic [$bits(side2_t)-1:0] side2_bits;
    logic div2_vld;
    logic [RATIO_W-1:0] q2, s2, t2;

    logic vld_l1_reg, vld_l2_reg, vld_l3_reg;
    logic signed [COORD_WIDTH-1:0] p1x_l1_reg, p1y_l1_reg, p2x_l1_reg, p2y_l1_reg;
    logic signed [M_W-1:0] m1x_l1_reg, m1y_l1_reg, m2x_l1_reg, m2y_l1_reg;
    pts_t pts_l2_reg, pts_l3_reg, pts_out;
    logic signed [DIFF_W-1:0] gx, gy;
    logic signed [SUM_W-1:0] gxx, gyy;
    logic [SUM_W-1:0] sum_l3_reg;
    logic [$bits(pts_t)-1:0] pts_bits;
    logic [GAP_W-1:0] root;

    assign en = !result_valid || result_ready;
    assign request_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degenerate_limit_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            degenerate_limit_reg <= cfg_write_data;
        end
    end

    scp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (request_valid),
        .request (request),
        .limit   (degenerate_limit_reg),
        .out_vld (front_vld),
        .front   (front)
    );

    always_comb
    begin
        priority if (front.a_pt && front.e_pt)
        begin
            num1 = '0;
            den1 = '0;
        end
        else if (front.a_pt)
        begin
            num1 = QUAD_W'($signed(front.geo.f));
            den1 = QUAD_W'($signed(front.geo.e));
        end
        else if (front.e_pt)
        begin
            num1 = -QUAD_W'($signed(front.geo.c));
            den1 = QUAD_W'($signed(front.geo.a));
        end
        else
        begin
            num1 = front.snum;
            den1 = front.denom;
        end
        side1_in.geo  = front.geo;
        side1_in.a_pt = front.a_pt;
        side1_in.e_pt = front.e_pt;
    end

    scp_div #(
        .NUM_W  (QUAD_W),
        .DEN_W  (QUAD_W),
        .SIDE_W ($bits(side1_t))
    ) u_div_first (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (front_vld),
        .num      (num1),
        .den      (den1),
        .side_in  (side1_in),
        .out_vld  (div1_vld),
        .quo      (q1),
        .side_out (side1_bits)
    );

    assign side1_out = side1_t'(side1_bits);
    assign s1 = side1_out.a_pt ? '0 : q1;
    assign t1 = (side1_out.a_pt && !side1_out.e_pt) ? q1 : '0;

    always_comb
    begin
        side2_next.p1x = geo_t2_reg.p1x;
        side2_next.p1y = geo_t2_reg.p1y;
        side2_next.p2x = geo_t2_reg.p2x;
        side2_next.p2y = geo_t2_reg.p2y;
        side2_next.d1x = geo_t2_reg.d1x;
        side2_next.d1y = geo_t2_reg.d1y;
        side2_next.d2x = geo_t2_reg.d2x;
        side2_next.d2y = geo_t2_reg.d2y;
        side2_next.s = s_t2_reg;
        side2_next.t = t_t2_reg;
        side2_next.tgt_s = 1'b0;
        side2_next.tgt_t = general_t2_reg;
        num2_next = tn_t2_reg;
        den2_next = tden_t2_reg;
        if (general_t2_reg && (tn_t2_reg < 0))
        begin
            side2_next.t = '0;
            side2_next.tgt_s = 1'b1;
            side2_next.tgt_t = 1'b0;
            num2_next = -TN_W'($signed(geo_t2_reg.c));
            den2_next = TN_W'($signed(geo_t2_reg.a));
        end
        else if (general_t2_reg && (tn_t2_reg > tden_t2_reg))
        begin
            side2_next.t = RATIO_ONE;
            side2_next.tgt_s = 1'b1;
            side2_next.tgt_t = 1'b0;
            num2_next = TN_W'($signed(geo_t2_reg.b)) - TN_W'($signed(geo_t2_reg.c));
            den2_next = TN_W'($signed(geo_t2_reg.a));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_t1_reg <= 1'b0;
            vld_t2_reg <= 1'b0;
            vld_t3_reg <= 1'b0;
            vld_l1_reg <= 1'b0;
            vld_l2_reg <= 1'b0;
            vld_l3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_t1_reg <= div1_vld;
            vld_t2_reg <= vld_t1_reg;
            vld_t3_reg <= vld_t2_reg;
            vld_l1_reg <= div2_vld;
            vld_l2_reg <= vld_l1_reg;
            vld_l3_reg <= vld_l2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_t1_reg     <= side1_out.geo;
            general_t1_reg <= !side1_out.a_pt && !side1_out.e_pt;
            s_t1_reg       <= s1;
            t_t1_reg       <= t1;
            bs_t1_reg      <= BS_W'($signed(side1_out.geo.b)) * BS_W'($signed({1'b0, s1}));

            geo_t2_reg     <= geo_t1_reg;
            general_t2_reg <= general_t1_reg;
            s_t2_reg       <= s_t1_reg;
            t_t2_reg       <= t_t1_reg;
            tn_t2_reg      <= TN_W'(bs_t1_reg)
                + (TN_W'($signed(geo_t1_reg.f)) <<< RATIO_FRACTION_BITS);
            tden_t2_reg    <= TN_W'($signed(geo_t1_reg.e)) <<< RATIO_FRACTION_BITS;

            num2_reg  <= num2_next;
            den2_reg  <= den2_next;
            side2_reg <= side2_next;
        end
    end

    scp_div #(
        .NUM_W  (TN_W),
        .DEN_W  (TN_W),
        .SIDE_W ($bits(side2_t))
    ) u_div_second (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld_t3_reg),
        .num      (num2_reg),
        .den      (den2_reg),
        .side_in  (side2_reg),
        .out_vld  (div2_vld),
        .quo      (q2),
        .side_out (side2_bits)
    );

    assign side2_out = side2_t'(side2_bits);
    assign s2 = side2_out.tgt_s ? q2 : side2_out.s;
    assign t2 = side2_out.tgt_t ? q2 : side2_out.t;

    assign gx = DIFF_W'($signed(pts_l2_reg.c2x)) - DIFF_W'($signed(pts_l2_reg.c1x));
    assign gy = DIFF_W'($signed(pts_l2_reg.c2y)) - DIFF_W'($signed(pts_l2_reg.c1y));
    assign gxx = SUM_W'(gx) * SUM_W'(gx);
    assign gyy = SUM_W'(gy) * SUM_W'(gy);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1x_l1_reg <= side2_out.p1x;
            p1y_l1_reg <= side2_out.p1y;
            p2x_l1_reg <= side2_out.p2x;
            p2y_l1_reg <= side2_out.p2y;
            m1x_l1_reg <= M_W'($signed(side2_out.d1x)) * M_W'($signed({1'b0, s2}));
            m1y_l1_reg <= M_W'($signed(side2_out.d1y)) * M_W'($signed({1'b0, s2}));
            m2x_l1_reg <= M_W'($signed(side2_out.d2x)) * M_W'($signed({1'b0, t2}));
            m2y_l1_reg <= M_W'($signed(side2_out.d2y)) * M_W'($signed({1'b0, t2}));

            pts_l2_reg.c1x <= step_along(p1x_l1_reg, m1x_l1_reg);
            pts_l2_reg.c1y <= step_along(p1y_l1_reg, m1y_l1_reg);
            pts_l2_reg.c2x <= step_along(p2x_l1_reg, m2x_l1_reg);
            pts_l2_reg.c2y <= step_along(p2y_l1_reg, m2y_l1_reg);

            pts_l3_reg <= pts_l2_reg;
            sum_l3_reg <= $unsigned(gxx + gyy);
        end
    end

    scp_sqrt #(
        .SUM_W  (SUM_W),
        .ROOT_W (GAP_W),
        .SIDE_W ($bits(pts_t))
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld_l3_reg),
        .sum      (sum_l3_reg),
        .side_in  (pts_l3_reg),
        .out_vld  (result_valid),
        .root     (root),
        .side_out (pts_bits)
    );

    assign pts_out = pts_t'(pts_bits);
    assign result.near_first_x  = pts_out.c1x;
    assign result.near_first_y  = pts_out.c1y;
    assign result.near_second_x = pts_out.c2x;
    assign result.near_second_y = pts_out.c2y;
    assign result.gap_length    = root;

endmodule

### src/scp_checker.sv
// Port-level checks for the segment closest points pipeline, bound to the top level.
module scp_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  request_valid,
    input logic                  request_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input scp_pkg::scp_result_t  result
);
    import scp_pkg::*;

    // With no result waiting, the pipeline is free to advance.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> request_ready)
        else $error("request_ready low with no result pending");

    // A request is refused only while a finished result is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && !request_ready |-> result_valid && !result_ready)
        else $error("request refused without a blocked result");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

endmodule

bind segment_closest_points_2d scp_checker u_scp_checker (.*);
